/* hw/rtl/yfc_pkg.sv */
`timescale 1ns / 1ps

package yfc_pkg;

    localparam int COEF_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_W     = 2;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_X       = 3'd0,
        REG_COEF_Y       = 3'd1,
        REG_COEF_Z       = 3'd2,
        REG_CURRENT_COEF = 3'd3,
        REG_DIM          = 3'd4
    } t_reg_idx;

    // component select; codes 6 and 7 pass old_value through
    typedef enum logic [2:0] {
        REQ_BX = 3'd0,
        REQ_BY = 3'd1,
        REQ_BZ = 3'd2,
        REQ_EX = 3'd3,
        REQ_EY = 3'd4,
        REQ_EZ = 3'd5
    } t_req_type;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [COEF_BITS-1:0] coef_x;
        logic [COEF_BITS-1:0] coef_y;
        logic [COEF_BITS-1:0] coef_z;
        logic [DIM_W-1:0]     dim;
    } t_axis_cfg;

    function automatic logic [COEF_BITS-1:0] axis_coef(t_axis axis, t_axis_cfg cfg);
        logic [COEF_BITS-1:0] c;
        case (axis)
            AXIS_X:  c = cfg.coef_x;
            AXIS_Y:  c = cfg.coef_y;
            default: c = cfg.coef_z;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/yfc_if.sv */
`timescale 1ns / 1ps

interface yfc_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    req_type;
    logic signed [VALUE_WIDTH-1:0] old_value;
    logic signed [VALUE_WIDTH-1:0] first_here;
    logic signed [VALUE_WIDTH-1:0] first_other;
    logic signed [VALUE_WIDTH-1:0] second_here;
    logic signed [VALUE_WIDTH-1:0] second_other;
    logic signed [VALUE_WIDTH-1:0] current_density;

    modport source (
        output valid, req_type, old_value, first_here, first_other,
               second_here, second_other, current_density,
        input  ready
    );
    modport sink (
        input  valid, req_type, old_value, first_here, first_other,
               second_here, second_other, current_density,
        output ready
    );
endinterface

interface yfc_out_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic                          saturated;

    modport source (
        output valid, new_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_value, saturated,
        output ready
    );
endinterface

/* hw/rtl/yfc_select.sv */
`timescale 1ns / 1ps

// Stage 1: decode component, form signed differences, pick coefficients.
module yfc_select #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  logic [2:0]                             i_req_type,
    input  logic signed [VALUE_WIDTH-1:0]          i_old,
    input  logic signed [VALUE_WIDTH-1:0]          i_first_here,
    input  logic signed [VALUE_WIDTH-1:0]          i_first_other,
    input  logic signed [VALUE_WIDTH-1:0]          i_second_here,
    input  logic signed [VALUE_WIDTH-1:0]          i_second_other,
    input  logic signed [VALUE_WIDTH-1:0]          i_current_density,
    input  yfc_pkg::t_axis_cfg                     i_cfg,
    input  logic signed [VALUE_WIDTH-1:0]          i_current_coef,
    output logic                                   o_valid,
    output logic signed [VALUE_WIDTH:0]            o_d1,
    output logic signed [VALUE_WIDTH:0]            o_d2,
    output logic [yfc_pkg::COEF_BITS-1:0]          o_c1,
    output logic [yfc_pkg::COEF_BITS-1:0]          o_c2,
    output logic signed [VALUE_WIDTH-1:0]          o_cc,
    output logic signed [VALUE_WIDTH-1:0]          o_cd,
    output logic signed [VALUE_WIDTH-1:0]          o_old
);
    import yfc_pkg::*;

    localparam int D = VALUE_WIDTH + 1;

    logic                  known;
    logic                  is_b;
    t_axis                 a1;
    t_axis                 a2;
    logic signed [D-1:0]   raw1;
    logic signed [D-1:0]   raw2;
    logic [COEF_BITS-1:0]  sel1;
    logic [COEF_BITS-1:0]  sel2;

    logic                  r_valid;
    logic signed [D-1:0]   r_d1, n_d1;
    logic signed [D-1:0]   r_d2, n_d2;
    logic [COEF_BITS-1:0]  r_c1, n_c1;
    logic [COEF_BITS-1:0]  r_c2, n_c2;
    logic signed [VALUE_WIDTH-1:0] r_cc, n_cc;
    logic signed [VALUE_WIDTH-1:0] r_cd;
    logic signed [VALUE_WIDTH-1:0] r_old;

    always_comb begin
        known = 1'b1;
        is_b  = 1'b0;
        a1    = AXIS_X;
        a2    = AXIS_X;
        case (t_req_type'(i_req_type))
            REQ_BX: begin is_b = 1'b1; a1 = AXIS_Z; a2 = AXIS_Y; end
            REQ_BY: begin is_b = 1'b1; a1 = AXIS_X; a2 = AXIS_Z; end
            REQ_BZ: begin is_b = 1'b1; a1 = AXIS_Y; a2 = AXIS_X; end
            REQ_EX: begin a1 = AXIS_Y; a2 = AXIS_Z; end
            REQ_EY: begin a1 = AXIS_Z; a2 = AXIS_X; end
            REQ_EZ: begin a1 = AXIS_X; a2 = AXIS_Y; end
            default: begin known = 1'b0; end
        endcase
    end

    always_comb begin
        raw1 = D'(i_first_here) - D'(i_first_other);
        raw2 = D'(i_second_here) - D'(i_second_other);
        // E differences run other minus here
        n_d1 = is_b ? raw1 : -raw1;
        n_d2 = is_b ? raw2 : -raw2;

        sel1 = axis_coef(a1, i_cfg);
        sel2 = axis_coef(a2, i_cfg);
        if (is_b) begin
            sel1 = sel1 >> 1;
            sel2 = sel2 >> 1;
        end
        // a zero coefficient drops the term (absent axis or unused code)
        n_c1 = (known && (a1 < i_cfg.dim)) ? sel1 : '0;
        n_c2 = (known && (a2 < i_cfg.dim)) ? sel2 : '0;
        n_cc = (known && !is_b) ? i_current_coef : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_c1  <= n_c1;
            r_c2  <= n_c2;
            r_cc  <= n_cc;
            r_cd  <= i_current_density;
            r_old <= i_old;
        end
    end

    assign o_valid = r_valid;
    assign o_d1    = r_d1;
    assign o_d2    = r_d2;
    assign o_c1    = r_c1;
    assign o_c2    = r_c2;
    assign o_cc    = r_cc;
    assign o_cd    = r_cd;
    assign o_old   = r_old;
endmodule

/* hw/rtl/yfc_mult.sv */
`timescale 1ns / 1ps

// Stage 2: difference products and the current product as two half products.
module yfc_mult #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_adv,
    input  logic                                               i_valid,
    input  logic signed [VALUE_WIDTH:0]                        i_d1,
    input  logic signed [VALUE_WIDTH:0]                        i_d2,
    input  logic [yfc_pkg::COEF_BITS-1:0]                      i_c1,
    input  logic [yfc_pkg::COEF_BITS-1:0]                      i_c2,
    input  logic signed [VALUE_WIDTH-1:0]                      i_cc,
    input  logic signed [VALUE_WIDTH-1:0]                      i_cd,
    input  logic signed [VALUE_WIDTH-1:0]                      i_old,
    output logic                                               o_valid,
    output logic signed [VALUE_WIDTH+yfc_pkg::COEF_BITS+1:0]   o_p1,
    output logic signed [VALUE_WIDTH+yfc_pkg::COEF_BITS+1:0]   o_p2,
    output logic signed [VALUE_WIDTH+VALUE_WIDTH/2:0]          o_pl,
    output logic signed [2*VALUE_WIDTH-VALUE_WIDTH/2-1:0]      o_ph,
    output logic signed [VALUE_WIDTH-1:0]                      o_old
);
    import yfc_pkg::*;

    localparam int D  = VALUE_WIDTH + 1;
    localparam int P  = D + COEF_BITS + 1;
    localparam int L  = VALUE_WIDTH / 2;
    localparam int H  = VALUE_WIDTH - L;
    localparam int PL = VALUE_WIDTH + L + 1;
    localparam int PH = VALUE_WIDTH + H;

    logic                    r_valid;
    logic signed [P-1:0]     r_p1, n_p1;
    logic signed [P-1:0]     r_p2, n_p2;
    logic signed [PL-1:0]    r_pl, n_pl;
    logic signed [PH-1:0]    r_ph, n_ph;
    logic signed [VALUE_WIDTH-1:0] r_old;

    always_comb begin
        n_p1 = P'(i_d1) * P'($signed({1'b0, i_c1}));
        n_p2 = P'(i_d2) * P'($signed({1'b0, i_c2}));
        // low half of the density is unsigned, high half carries the sign
        n_pl = PL'(i_cc) * PL'($signed({1'b0, i_cd[L-1:0]}));
        n_ph = PH'(i_cc) * PH'($signed(i_cd[VALUE_WIDTH-1:L]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_pl  <= n_pl;
            r_ph  <= n_ph;
            r_old <= i_old;
        end
    end

    assign o_valid = r_valid;
    assign o_p1    = r_p1;
    assign o_p2    = r_p2;
    assign o_pl    = r_pl;
    assign o_ph    = r_ph;
    assign o_old   = r_old;
endmodule

/* hw/rtl/yfc_combine.sv */
`timescale 1ns / 1ps

// Stage 3: floor the difference terms, sum them with the old value,
// and join the two current half products.
module yfc_combine #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_adv,
    input  logic                                               i_valid,
    input  logic signed [VALUE_WIDTH+yfc_pkg::COEF_BITS+1:0]   i_p1,
    input  logic signed [VALUE_WIDTH+yfc_pkg::COEF_BITS+1:0]   i_p2,
    input  logic signed [VALUE_WIDTH+VALUE_WIDTH/2:0]          i_pl,
    input  logic signed [2*VALUE_WIDTH-VALUE_WIDTH/2-1:0]      i_ph,
    input  logic signed [VALUE_WIDTH-1:0]                      i_old,
    output logic                                               o_valid,
    output logic signed [VALUE_WIDTH+2:0]                      o_dsum,
    output logic signed [2*VALUE_WIDTH:0]                      o_full
);
    import yfc_pkg::*;

    localparam int D  = VALUE_WIDTH + 1;
    localparam int P  = D + COEF_BITS + 1;
    localparam int TW = P - COEF_BITS;
    localparam int SW = VALUE_WIDTH + 3;
    localparam int L  = VALUE_WIDTH / 2;
    localparam int FW = 2 * VALUE_WIDTH + 1;

    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [FW-1:0] ph_shift;

    logic                 r_valid;
    logic signed [SW-1:0] r_dsum, n_dsum;
    logic signed [FW-1:0] r_full, n_full;

    always_comb begin
        // dropping the low bits of a signed value is a floor shift
        t1       = i_p1[P-1:COEF_BITS];
        t2       = i_p2[P-1:COEF_BITS];
        n_dsum   = SW'(i_old) + SW'(t1) - SW'(t2);
        ph_shift = FW'(i_ph) <<< L;
        n_full   = ph_shift + FW'(i_pl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dsum <= n_dsum;
            r_full <= n_full;
        end
    end

    assign o_valid = r_valid;
    assign o_dsum  = r_dsum;
    assign o_full  = r_full;
endmodule

/* hw/rtl/yfc_sat.sv */
`timescale 1ns / 1ps

// Stage 4: add the floored current term, clamp once, hold the result.
module yfc_sat #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [VALUE_WIDTH+2:0] i_dsum,
    input  logic signed [2*VALUE_WIDTH:0] i_full,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_saturated
);
    localparam int FW = 2 * VALUE_WIDTH + 1;
    localparam int AW = FW + 1;

    logic signed [FW-1:0] cur;
    logic signed [AW-1:0] acc;
    logic                 ovf;

    logic                          r_valid;
    logic signed [VALUE_WIDTH-1:0] r_value, n_value;
    logic                          r_sat, n_sat;

    always_comb begin
        cur = i_full >>> FRAC_BITS;
        acc = AW'(cur) + AW'(i_dsum);
        // in range only if every bit from the sign down to bit W-1 agrees
        ovf = !((&acc[AW-1:VALUE_WIDTH-1]) || !(|acc[AW-1:VALUE_WIDTH-1]));
        n_sat = ovf;
        if (!ovf) begin
            n_value = acc[VALUE_WIDTH-1:0];
        end else if (acc[AW-1]) begin
            n_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;
endmodule

/* hw/rtl/yee_fdtd_cell_update_top.sv */
`timescale 1ns / 1ps

// Yee curl update for one field component (Bx..Ez) of one cell in signed
// fixed point. Takes one item per clock unless the output stalls. The four
// register stages are select and differences, multiplies, term combine,
// current add and clamp. The depth of each stage is bounded by the
// multipliers (difference x 16-bit coef and the current product split into
// two half-width products). All stages advance together whenever the
// output register is empty or being taken, so a stall holds every item in
// place. Configuration registers (coef_x, coef_y, coef_z, current_coef,
// dimensionality) are written through the plain write port; the user must
// write them only while no item is in flight; not enforced by the block.
// B updates use the halved axis coefficients; terms along axes at or above
// dimensionality drop out. req_type codes 6 and 7 pass old_value unchanged.
module yee_fdtd_cell_update_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    yfc_in_if.sink                            i_in,
    yfc_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [yfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [VALUE_WIDTH-1:0]            i_cfg_data
);
    import yfc_pkg::*;

    localparam int D  = VALUE_WIDTH + 1;
    localparam int P  = D + COEF_BITS + 1;
    localparam int L  = VALUE_WIDTH / 2;
    localparam int PL = VALUE_WIDTH + L + 1;
    localparam int PH = 2 * VALUE_WIDTH - L;

    // configuration
    t_axis_cfg                     r_cfg;
    logic signed [VALUE_WIDTH-1:0] r_current_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_x   <= COEF_BITS'(32768);
            r_cfg.coef_y   <= COEF_BITS'(32768);
            r_cfg.coef_z   <= COEF_BITS'(32768);
            r_cfg.dim      <= DIM_W'(3);
            r_current_coef <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COEF_X:       r_cfg.coef_x   <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_Y:       r_cfg.coef_y   <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_Z:       r_cfg.coef_z   <= i_cfg_data[COEF_BITS-1:0];
                REG_CURRENT_COEF: r_current_coef <= $signed(i_cfg_data);
                REG_DIM:          r_cfg.dim      <= i_cfg_data[DIM_W-1:0];
                default: begin end
            endcase
        end
    end

    // one enable for the whole pipe: move when the output slot frees up
    logic adv;
    assign adv        = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    logic                          s1_valid;
    logic signed [D-1:0]           s1_d1, s1_d2;
    logic [COEF_BITS-1:0]          s1_c1, s1_c2;
    logic signed [VALUE_WIDTH-1:0] s1_cc, s1_cd, s1_old;

    yfc_select #(.VALUE_WIDTH(VALUE_WIDTH)) u_select (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (adv),
        .i_valid           (i_in.valid),
        .i_req_type        (i_in.req_type),
        .i_old             (i_in.old_value),
        .i_first_here      (i_in.first_here),
        .i_first_other     (i_in.first_other),
        .i_second_here     (i_in.second_here),
        .i_second_other    (i_in.second_other),
        .i_current_density (i_in.current_density),
        .i_cfg             (r_cfg),
        .i_current_coef    (r_current_coef),
        .o_valid           (s1_valid),
        .o_d1              (s1_d1),
        .o_d2              (s1_d2),
        .o_c1              (s1_c1),
        .o_c2              (s1_c2),
        .o_cc              (s1_cc),
        .o_cd              (s1_cd),
        .o_old             (s1_old)
    );

    logic                          s2_valid;
    logic signed [P-1:0]           s2_p1, s2_p2;
    logic signed [PL-1:0]          s2_pl;
    logic signed [PH-1:0]          s2_ph;
    logic signed [VALUE_WIDTH-1:0] s2_old;

    yfc_mult #(.VALUE_WIDTH(VALUE_WIDTH)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s1_valid),
        .i_d1    (s1_d1),
        .i_d2    (s1_d2),
        .i_c1    (s1_c1),
        .i_c2    (s1_c2),
        .i_cc    (s1_cc),
        .i_cd    (s1_cd),
        .i_old   (s1_old),
        .o_valid (s2_valid),
        .o_p1    (s2_p1),
        .o_p2    (s2_p2),
        .o_pl    (s2_pl),
        .o_ph    (s2_ph),
        .o_old   (s2_old)
    );

    logic                            s3_valid;
    logic signed [VALUE_WIDTH+2:0]   s3_dsum;
    logic signed [2*VALUE_WIDTH:0]   s3_full;

    yfc_combine #(.VALUE_WIDTH(VALUE_WIDTH)) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s2_valid),
        .i_p1    (s2_p1),
        .i_p2    (s2_p2),
        .i_pl    (s2_pl),
        .i_ph    (s2_ph),
        .i_old   (s2_old),
        .o_valid (s3_valid),
        .o_dsum  (s3_dsum),
        .o_full  (s3_full)
    );

    yfc_sat #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (s3_valid),
        .i_dsum      (s3_dsum),
        .i_full      (s3_full),
        .o_valid     (o_out.valid),
        .o_value     (o_out.new_value),
        .o_saturated (o_out.saturated)
    );
endmodule

/* hw/rtl/yfc_checker.sv */
`timescale 1ns / 1ps

module yfc_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_WIDTH-1:0] i_new_value,
    input logic                   i_saturated
);
    localparam logic [VALUE_WIDTH-1:0] MAXV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MINV = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // pipe advances exactly when the output slot is free or being drained
    a_ready_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot state");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a clamped result sits at one of the range ends
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_saturated) |-> (i_new_value == MAXV || i_new_value == MINV))
        else $error("saturated result not at range limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_new_value) && $stable(i_saturated)))
        else $error("result changed while stalled");
endmodule

bind yee_fdtd_cell_update_top yfc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_yfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_new_value (o_out.new_value),
    .i_saturated (o_out.saturated)
);

/* verif/yfc_cell_checker.sv */
`timescale 1ns / 1ps

module yfc_cell_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    yfc_in_if                             i_in,
    yfc_out_if                            i_out,
    input  logic                          i_cfg_we,
    input  logic [yfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VALUE_WIDTH-1:0]        i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import yfc_pkg::*;

    // wide enough for difference x coef and the full current product
    localparam int WIDE = 2 * VALUE_WIDTH + 24;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [WIDE-1:0]        t_wide;
    typedef struct packed {
        t_value new_value;
        logic   saturated;
    } t_cell_result;

    localparam t_wide VAL_MAX = t_wide'({(VALUE_WIDTH-1){1'b1}});
    localparam t_wide VAL_MIN = ~VAL_MAX;

    logic [COEF_BITS-1:0] coef_of_axis [3];
    t_value               cur_coef;
    logic [DIM_W-1:0]     dim_q;
    t_cell_result         expected_q [$];
    int                   fails = 0;

    function automatic t_cell_result cell_update(input logic [2:0] req, input t_value old_v,
                                                 input t_value fh, input t_value fo,
                                                 input t_value sh, input t_value so,
                                                 input t_value jd);
        t_axis        ax1, ax2;
        logic         is_b, is_e;
        t_wide        acc, d1, d2, c1, c2;
        t_cell_result r;
        is_b = 1'b0;
        is_e = 1'b0;
        ax1  = AXIS_X;
        ax2  = AXIS_X;
        case (req)
            REQ_BX: begin is_b = 1'b1; ax1 = AXIS_Z; ax2 = AXIS_Y; end
            REQ_BY: begin is_b = 1'b1; ax1 = AXIS_X; ax2 = AXIS_Z; end
            REQ_BZ: begin is_b = 1'b1; ax1 = AXIS_Y; ax2 = AXIS_X; end
            REQ_EX: begin is_e = 1'b1; ax1 = AXIS_Y; ax2 = AXIS_Z; end
            REQ_EY: begin is_e = 1'b1; ax1 = AXIS_Z; ax2 = AXIS_X; end
            REQ_EZ: begin is_e = 1'b1; ax1 = AXIS_X; ax2 = AXIS_Y; end
            default: ;
        endcase
        acc = old_v;
        if (is_b || is_e) begin
            d1 = fh - fo;
            d2 = sh - so;
            c1 = t_wide'(coef_of_axis[ax1]);
            c2 = t_wide'(coef_of_axis[ax2]);
            if (is_e) begin
                // E takes other minus here
                d1 = -d1;
                d2 = -d2;
            end else begin
                c1 = c1 >> 1;
                c2 = c2 >> 1;
            end
            if (ax1 < dim_q)
                acc = acc + ((d1 * c1) >>> COEF_BITS);
            if (ax2 < dim_q)
                acc = acc - ((d2 * c2) >>> COEF_BITS);
            if (is_e)
                acc = acc + ((cur_coef * jd) >>> FRAC_BITS);
        end
        r.saturated = 1'b1;
        if (acc > VAL_MAX)
            r.new_value = VAL_MAX[VALUE_WIDTH-1:0];
        else if (acc < VAL_MIN)
            r.new_value = VAL_MIN[VALUE_WIDTH-1:0];
        else begin
            r.new_value = acc[VALUE_WIDTH-1:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result want, got;
        if (!i_rst_n) begin
            coef_of_axis[AXIS_X] = 16'd32768;
            coef_of_axis[AXIS_Y] = 16'd32768;
            coef_of_axis[AXIS_Z] = 16'd32768;
            cur_coef             = '0;
            dim_q                = 2'd3;
            expected_q.delete();
        end else begin
            // retire first: a result is always older than an item taken this edge
            if (i_out.valid && i_out.ready) begin
                got.new_value = i_out.new_value;
                got.saturated = i_out.saturated;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected: new_value %h saturated %b",
                             $time, got.new_value, got.saturated);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected new_value %h saturated %b, got %h %b",
                                 $time, want.new_value, want.saturated,
                                 got.new_value, got.saturated);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(cell_update(i_in.req_type, i_in.old_value,
                                                 i_in.first_here, i_in.first_other,
                                                 i_in.second_here, i_in.second_other,
                                                 i_in.current_density));
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_COEF_X:       coef_of_axis[AXIS_X] = i_cfg_data[COEF_BITS-1:0];
                    REG_COEF_Y:       coef_of_axis[AXIS_Y] = i_cfg_data[COEF_BITS-1:0];
                    REG_COEF_Z:       coef_of_axis[AXIS_Z] = i_cfg_data[COEF_BITS-1:0];
                    REG_CURRENT_COEF: cur_coef             = i_cfg_data;
                    REG_DIM:          dim_q                = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

/* verif/tb_yee_fdtd_cell_update_top.sv */
`timescale 1ns / 1ps

module tb_yee_fdtd_cell_update_top;
    import yfc_pkg::*;

    localparam int VW             = 32;
    localparam int FB             = 16;
    localparam int RAND_PER_PHASE = 417;   // three phases, ~1250 random items
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int SETTLE_TAIL    = 12;    // pipeline is 4 deep; a few spare cycles

    // req_type codes with no component: the block passes old_value through
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    typedef logic signed [VW-1:0] t_value;

    localparam t_value V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_value V_MIN = {1'b1, {(VW-1){1'b0}}};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VW-1:0]        cfg_data;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   fail_count;
    int                   pending;
    int                   stall_cycles = 0;

    yfc_in_if  #(.VALUE_WIDTH(VW)) cell_in  ();
    yfc_out_if #(.VALUE_WIDTH(VW)) cell_out ();

    yee_fdtd_cell_update_top #(
        .VALUE_WIDTH (VW),
        .FRAC_BITS   (FB)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (cell_in),
        .o_out      (cell_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predicts every accepted item and scores each returned result.
    yfc_cell_checker #(
        .VALUE_WIDTH (VW),
        .FRAC_BITS   (FB)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (cell_in),
        .i_out        (cell_out),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side backpressure; rx_idle_pct of 0 keeps ready high throughout.
    always @(posedge clk) begin
        cell_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hang detector: a lost result leaves the settle wait spinning, which lands here.
    always @(posedge clk) begin
        if (!rst_n || (cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One item; may idle the valid line first. Returns at the accepting edge
    // with valid still high so back-to-back items never drop it.
    task automatic send_cell(input logic [2:0] req, input t_value old_v,
                             input t_value fh, input t_value fo,
                             input t_value sh, input t_value so, input t_value jd);
        // each cycle idles with tx_idle_pct percent chance
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cell_in.valid <= 1'b0;
            @(posedge clk);
        end
        cell_in.valid           <= 1'b1;
        cell_in.req_type        <= req;
        cell_in.old_value       <= old_v;
        cell_in.first_here      <= fh;
        cell_in.first_other     <= fo;
        cell_in.second_here     <= sh;
        cell_in.second_other    <= so;
        cell_in.current_density <= jd;
        do @(posedge clk); while (!cell_in.ready);
    endtask

    // Hold off the sender until every outstanding result is back.
    // The opening wait lets the checker's count catch the last item.
    task automatic wait_results_settled();
        cell_in.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [VW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Full register reload, only with the pipe empty.
    task automatic load_config(input logic [15:0] cx, input logic [15:0] cy,
                               input logic [15:0] cz, input t_value cj,
                               input logic [1:0] dim);
        wait_results_settled();
        cfg_write(REG_COEF_X, VW'(cx));
        cfg_write(REG_COEF_Y, VW'(cy));
        cfg_write(REG_COEF_Z, VW'(cz));
        cfg_write(REG_CURRENT_COEF, cj);
        cfg_write(REG_DIM, VW'(dim));
        cfg_we <= 1'b0;
    endtask

    // Mix of rails, unit values, modest Q16.16 magnitudes and raw noise.
    function automatic t_value rand_value();
        case ($urandom_range(0, 11))
            0:          return V_MAX;
            1:          return V_MIN;
            2:          return '0;
            3:          return t_value'(-1);
            4, 5, 6, 7: return t_value'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default:    return t_value'($urandom);
        endcase
    endfunction

    // Neighbor values usually sit close to each other on a real grid.
    function automatic t_value near(input t_value v);
        if ($urandom_range(0, 3) == 0)
            return rand_value();
        return v + t_value'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_cell();
        logic [2:0] req;
        t_value     fh, sh;
        // mostly real components, the odd unused code
        if ($urandom_range(0, 15) == 0)
            req = REQ_RSVD6 + 3'($urandom_range(0, 1));
        else
            req = 3'($urandom_range(REQ_BX, REQ_EZ));
        fh = rand_value();
        sh = rand_value();
        send_cell(req, rand_value(), fh, near(fh), sh, near(sh), rand_value());
    endtask

    initial begin
        int sent;
        int chunk;

        cell_in.valid           = 1'b0;
        cell_in.req_type        = '0;
        cell_in.old_value       = '0;
        cell_in.first_here      = '0;
        cell_in.first_other     = '0;
        cell_in.second_here     = '0;
        cell_in.second_other    = '0;
        cell_in.current_density = '0;
        cell_out.ready          = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = '0;
        cfg_data                = '0;
        rst_n                   = 1'b0;
        tx_idle_pct             = 29;
        rx_idle_pct             = 75;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (half coefs, no current, 3-D): every code once,
        // odd differences so the halved B coefs round by floor.
        for (int t = 0; t < 8; t++)
            send_cell(3'(t), 32'h0001_8000, 32'h0003_0001, -32'sh0001_0000,
                      32'h0000_8000, -32'sh0002_4003, 32'h0004_0000);

        // Full-scale coefs and most negative current coef: drive both rails.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, V_MIN, 2'd3);
        send_cell(REQ_EX, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN, V_MIN);   // clamps high
        send_cell(REQ_BX, V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX);   // clamps low
        send_cell(REQ_EZ, '0, '0, '0, '0, '0, V_MAX);                  // current term alone
        send_cell(REQ_BY, V_MAX, 32'sd1, '0, '0, '0, V_MIN);           // at the rail, no clamp
        send_cell(REQ_EY, '0, '0, '0, '0, '0, '0);
        send_cell(REQ_RSVD7, V_MIN, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX);
        send_cell(REQ_RSVD6, V_MAX, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN);

        // No axis active: B passes old value, E adds only the current term.
        load_config(16'h0000, 16'h0001, 16'hFFFF, V_MAX, 2'd0);
        for (int t = REQ_BX; t <= REQ_EZ; t++)
            send_cell(3'(t), 32'sd1, V_MAX, V_MIN, V_MIN, V_MAX, 32'h0001_0000);

        // 1-D with tiny odd coefs and a -1 current coef: negative floor rounding.
        load_config(16'd3, 16'd5, 16'd7, t_value'(-1), 2'd1);
        send_cell(REQ_BY, '0, t_value'(-1), '0, 32'sd5, '0, '0);
        send_cell(REQ_EZ, '0, '0, -32'sd3, '0, 32'sd9, t_value'(-1));
        send_cell(REQ_BZ, 32'sd7, 32'sd1, '0, t_value'(-1), '0, 32'sd1);

        // Random part: three backpressure profiles, registers reloaded per chunk.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 29; rx_idle_pct = 75; end
                1: begin tx_idle_pct = 75; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                load_config(rand_coef(), rand_coef(), rand_coef(), rand_value(),
                            2'($urandom_range(0, 3)));
                chunk = $urandom_range(40, 120);
                if (chunk > RAND_PER_PHASE - sent)
                    chunk = RAND_PER_PHASE - sent;
                repeat (chunk) begin
                    // occasional full drain mid-stream
                    if ($urandom_range(0, 59) == 0)
                        wait_results_settled();
                    send_random_cell();
                    sent++;
                end
            end
        end

        wait_results_settled();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* yee_fdtd_cell_update_top.f */
hw/rtl/yfc_pkg.sv
hw/rtl/yfc_if.sv
hw/rtl/yfc_select.sv
hw/rtl/yfc_mult.sv
hw/rtl/yfc_combine.sv
hw/rtl/yfc_sat.sv
hw/rtl/yee_fdtd_cell_update_top.sv
hw/rtl/yfc_checker.sv
verif/yfc_cell_checker.sv
verif/tb_yee_fdtd_cell_update_top.sv
